>>> sv/tgr_pkg.sv
// shared types and constants for the tile text glyph renderer
`timescale 1ns / 1ps

package tgr_pkg;

  localparam int FONT_BYTES_DEF    = 4096;
  localparam int MAX_ROW_CHARS_DEF = 16;

  // font byte address as it travels on the ports
  localparam int ADDR_W = 12;

  // input operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  // configuration register indexes
  localparam logic CFG_GLYPH_MODE = 1'b0;
  localparam logic CFG_ROW_CHARS  = 1'b1;

  // last byte index of a run
  localparam logic [3:0] SMALL_LAST = 4'd7;
  localparam logic [3:0] HALF_LAST  = 4'd15;

  // offset of the bottom half inside a 32-byte glyph
  localparam logic [4:0] BOTTOM_OFS = 5'b10000;

  // one result word
  typedef struct packed {
    logic       err;
    logic       last;
    logic [7:0] pixel;
  } beat_t;

  // output buffer status seen by the byte issue logic
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } buf_stat_t;

endpackage

>>> sv/tgr_font_mem.sv
// font store: single write port, single registered read port
`timescale 1ns / 1ps

module tgr_font_mem
  import tgr_pkg::*;
#(
  parameter int FONT_BYTES = FONT_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  localparam int AW = $clog2(FONT_BYTES);
  localparam int XW = ADDR_W + 2;
  localparam logic [XW-1:0] FB1 = XW'(FONT_BYTES);
  localparam logic [XW-1:0] FB2 = XW'(2 * FONT_BYTES);
  localparam logic [XW-1:0] FB3 = XW'(3 * FONT_BYTES);

  logic [7:0] mem_q [FONT_BYTES];
  logic [7:0] rdata_q;

  // address modulo the store size; the port address is below four times the size
  function automatic logic [AW-1:0] wrap(input logic [ADDR_W-1:0] a);
    logic [XW-1:0] x;
    x = {2'b00, a};
    if (x >= FB3) begin
      x = x - FB3;
    end else if (x >= FB2) begin
      x = x - FB2;
    end else if (x >= FB1) begin
      x = x - FB1;
    end
    return x[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wrap(waddr_i)] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[wrap(raddr_i)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tgr_row_mem.sv
// row buffer of character codes waiting for their bottom halves
`timescale 1ns / 1ps

module tgr_row_mem
  import tgr_pkg::*;
#(
  parameter int  MAX_ROW_CHARS = MAX_ROW_CHARS_DEF,
  localparam int RW            = (MAX_ROW_CHARS > 1) ? $clog2(MAX_ROW_CHARS) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [RW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [RW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [MAX_ROW_CHARS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tgr_out_buf.sv
// two-word output buffer in front of the result stream
`timescale 1ns / 1ps

module tgr_out_buf
  import tgr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  beat_t     beat_i,
  output buf_stat_t stat_o,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output logic [7:0] m_axis_tdata,   // pixel_byte
  output logic      m_axis_tlast,
  output logic      m_axis_tuser     // error
);

  beat_t      ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign m_axis_tvalid = (count_q != 2'd0);
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= beat_i;
    end
  end

  assign m_axis_tdata = ent_q[rptr_q].pixel;
  assign m_axis_tlast = ent_q[rptr_q].last;
  assign m_axis_tuser = ent_q[rptr_q].err;

  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && count_q == 2'd2 |-> pop)
    else $error("output buffer overflow");

endmodule

>>> sv/tile_text_glyph_renderer_top.sv
// top level of the tile text glyph renderer: sequencer around font and row memories
`timescale 1ns / 1ps

// Character generator for a page-organized monochrome display.
// Input stream: tuser[1:0] is the operation (load font byte, character, drain);
// tdata carries font address, font byte and character code. Output stream: one
// column byte per word in tdata, tlast on the final byte of an item, tuser set on
// an error word (pixel byte zero, tlast set).
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 glyph mode,
// 1 characters per row); write only while the block is idle.
// A font load gives no word. A character gives 8 (8x8) or 16 (16x16, top half)
// words; a drain gives 16 bottom-half words. Bytes come from the single font memory
// read port at one per cycle while the output buffer has room, and an item returns
// to idle in the cycle after its last byte is issued; a drain first reads the row
// buffer in a state of its own. The first word passes the font read register and
// the output buffer before it is valid, a drain adding the row buffer read.
// Items are handled one at a time: tready is high only between items.
// When the receiver stalls, font reads stop once the two-word output buffer and
// the read in flight fill it; nothing is dropped and issue resumes when words drain.
// Reset clears the sequencer, row counters and registers (8x8 mode, 16 characters
// per row); font and row memories keep their contents and must be loaded first.

module tile_text_glyph_renderer_top
  import tgr_pkg::*;
#(
  parameter int FONT_BYTES    = FONT_BYTES_DEF,
  parameter int MAX_ROW_CHARS = MAX_ROW_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // font_address, font_byte, char_code, zero pad
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // pixel_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // error
);

  localparam int RW = (MAX_ROW_CHARS > 1) ? $clog2(MAX_ROW_CHARS) : 1;
  localparam int CW = $clog2(MAX_ROW_CHARS + 1);
  localparam logic [5:0]    MAX6   = 6'(MAX_ROW_CHARS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CODE = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              mode_q;
  logic [4:0]        row_chars_q;
  logic [CW-1:0]     col_q, col_d;
  logic [CW-1:0]     pend_q, pend_d;
  logic [RW-1:0]     drain_q, drain_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [3:0]        last_idx_q, last_idx_d;
  logic              flip_q, flip_d;

  logic              rd_vld_q;
  logic              rd_last_q;
  logic              rd_err_q;
  logic              rd_flip_q;

  logic              accept;
  logic [1:0]        in_op;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_byte;
  logic [7:0]        in_code;

  logic [5:0]        limit6;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     col_inc;

  logic              font_we;
  logic              font_re;
  logic [ADDR_W-1:0] font_raddr;
  logic [7:0]        font_rdata;
  logic              row_we;
  logic              row_re;
  logic [7:0]        row_rdata;

  buf_stat_t         bstat;
  beat_t             beat;
  logic [2:0]        occupancy;
  logic              can_issue;
  logic              issue;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_op         = s_axis_tuser;
  assign in_addr       = s_axis_tdata[11:0];
  assign in_byte       = s_axis_tdata[19:12];
  assign in_code       = s_axis_tdata[27:20];

  // row length clamped to 1..MAX_ROW_CHARS
  always_comb begin
    limit6 = {1'b0, row_chars_q};
    if (limit6 == 6'd0) begin
      limit6 = 6'd1;
    end else if (limit6 > MAX6) begin
      limit6 = MAX6;
    end
    limit = limit6[CW-1:0];
  end

  assign col_inc = col_q + CNT_ONE;

  // words already buffered plus the read in flight must leave room
  assign occupancy = {1'b0, bstat.count} + {2'b00, rd_vld_q};
  assign can_issue = (occupancy <= 3'd1) || bstat.pop;
  assign issue     = ((state_q == S_RUN) || (state_q == S_ERR)) && can_issue;

  assign font_we    = accept && (in_op == OP_LOAD);
  assign font_re    = issue && (state_q == S_RUN);
  assign font_raddr = base_q + {8'b0, cnt_q};

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    pend_d     = pend_q;
    drain_d    = drain_q;
    base_d     = base_q;
    cnt_d      = cnt_q;
    last_idx_d = last_idx_q;
    flip_d     = flip_q;
    row_we     = 1'b0;
    row_re     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_LOAD: begin
              state_d = S_IDLE;
            end
            OP_CHAR: begin
              if (pend_q != '0) begin
                state_d = S_ERR;
              end else begin
                state_d = S_RUN;
                flip_d  = in_code[7];
                cnt_d   = 4'd0;
                if (!mode_q) begin
                  base_d     = {2'b00, in_code[6:0], 3'b000};
                  last_idx_d = SMALL_LAST;
                end else begin
                  base_d     = {in_code[6:0], 5'b00000};
                  last_idx_d = HALF_LAST;
                  row_we     = 1'b1;
                  if (col_inc >= limit) begin
                    pend_d  = col_inc;
                    drain_d = '0;
                    col_d   = '0;
                  end else begin
                    col_d = col_inc;
                  end
                end
              end
            end
            OP_DRAIN: begin
              if (pend_q == '0) begin
                state_d = S_ERR;
              end else begin
                state_d = S_CODE;
                row_re  = 1'b1;
                pend_d  = pend_q - CNT_ONE;
                if (pend_q == CNT_ONE) begin
                  drain_d = '0;
                end else begin
                  drain_d = drain_q + RW'(1);
                end
              end
            end
            default: begin
              state_d = S_ERR;
            end
          endcase
        end
      end
      S_CODE: begin
        // row buffer word is valid now
        state_d    = S_RUN;
        base_d     = {row_rdata[6:0], BOTTOM_OFS};
        flip_d     = row_rdata[7];
        cnt_d      = 4'd0;
        last_idx_d = HALF_LAST;
      end
      S_RUN: begin
        if (issue) begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == last_idx_q) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (issue) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      row_chars_q <= 5'd16;
      col_q       <= '0;
      pend_q      <= '0;
      drain_q     <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      pend_q   <= pend_d;
      drain_q  <= drain_d;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GLYPH_MODE: mode_q      <= cfg_data_i[0];
          CFG_ROW_CHARS:  row_chars_q <= cfg_data_i;
          default:        mode_q      <= mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    cnt_q      <= cnt_d;
    last_idx_q <= last_idx_d;
    flip_q     <= flip_d;
    rd_last_q  <= (state_q == S_ERR) || (cnt_q == last_idx_q);
    rd_err_q   <= (state_q == S_ERR);
    rd_flip_q  <= flip_q;
  end

  assign beat.err   = rd_err_q;
  assign beat.last  = rd_last_q;
  assign beat.pixel = rd_err_q ? 8'h00 : (font_rdata ^ {8{rd_flip_q}});

  tgr_font_mem #(
    .FONT_BYTES (FONT_BYTES)
  ) u_font_mem (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (in_addr),
    .wdata_i (in_byte),
    .re_i    (font_re),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  // writes and reads of the row buffer belong to different items, so never overlap
  tgr_row_mem #(
    .MAX_ROW_CHARS (MAX_ROW_CHARS)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (col_q[RW-1:0]),
    .wdata_i (in_code),
    .re_i    (row_re),
    .raddr_i (drain_q),
    .rdata_o (row_rdata)
  );

  tgr_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (rd_vld_q),
    .beat_i        (beat),
    .stat_o        (bstat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < CW'(MAX_ROW_CHARS))
    else $error("row column count out of range");

  a_pend_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0 |-> col_q == '0)
    else $error("row filling while bottom halves pending");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && state_q == S_RUN && cnt_q == last_idx_q |=> s_axis_tready)
    else $error("sequencer did not return to idle after last byte");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CW'(MAX_ROW_CHARS))
    else $error("pending bottom count out of range");

endmodule
